// File: rtl/core/wbss_pkg.sv
package wbss_pkg;

    // signature storage is fixed at two 64-bit registers
    localparam int SIG_BYTES       = 16;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LO = 3'd0,
        CFG_PAT_HI = 3'd1,
        CFG_WILD   = 3'd2,
        CFG_LEN    = 3'd3,
        CFG_BASE   = 3'd4
    } t_cfg_reg;

    // control broadcast to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// File: rtl/core/wbss_cell.sv
module wbss_cell
    import wbss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    input  logic [7:0] i_sig,
    input  logic       i_wild,
    input  logic       i_used,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output logic       o_ok
);

    logic [7:0] r_byte;
    logic       r_valid;

    // judge the byte this cell will hold after the shift
    assign o_ok    = !i_used || (i_valid && (i_wild || (i_byte == i_sig)));
    assign o_byte  = r_byte;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: rtl/core/wildcard_byte_signature_scan.sv
// Scans a memory region, one byte per word on the input stream (tlast marks the
// region's last byte), for a signature of up to 16 bytes in which any byte may be
// a wildcard. The first full match gives one result word with tuser = 1 and the
// address of the match's first byte (base_address + offset, modulo 2^32); a region
// that ends unmatched gives tuser = 0 and address 0. Bytes after a match are
// dropped until tlast, and the scan state clears after each region. One byte is
// taken every cycle while the output register is empty or draining; a result word
// held by back-pressure stalls the input until it leaves. The result shows on the
// output the cycle after its byte is taken. The cycle time is set by the
// compare across the row of window cells feeding the match AND and the address add.
// Write the registers only while the scan is idle.
module wildcard_byte_signature_scan
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // byte stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] mem_byte
    input  logic                   s_axis_tlast,  // region_end
    // result stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [ADDR_W-1:0]      m_axis_tdata,  // [31:0] match_address
    output logic                   m_axis_tuser   // found
);

    // configuration registers
    logic [63:0]          r_pat_lo;
    logic [63:0]          r_pat_hi;
    logic [SIG_BYTES-1:0] r_wild;
    logic [LEN_W-1:0]     r_pat_len;
    logic [ADDR_W-1:0]    r_base;

    // scan state
    logic [ADDR_W-1:0]    r_offset;
    logic [ADDR_W-1:0]    n_offset;
    logic                 r_done;
    logic                 n_done;

    // output register
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_found;
    logic [ADDR_W-1:0]    r_out_addr;

    logic                 w_accept;
    logic                 w_match;
    logic                 w_emit;
    logic [LEN_W-1:0]     w_len;
    logic [ADDR_W-1:0]    w_match_addr;
    logic [8*SIG_BYTES-1:0] w_sig;
    t_cell_ctl            w_ctl;

    logic [7:0]           w_cell_in   [MAX_PATTERN];
    logic                 w_valid_in  [MAX_PATTERN];
    logic [7:0]           w_cell_byte [MAX_PATTERN];
    logic                 w_cell_valid[MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_cell_ok;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_wild    <= '0;
            r_pat_len <= LEN_W'(1);
            r_base    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PAT_LO: r_pat_lo  <= i_cfg_wdata[63:0];
                CFG_PAT_HI: r_pat_hi  <= i_cfg_wdata[63:0];
                CFG_WILD:   r_wild    <= i_cfg_wdata[SIG_BYTES-1:0];
                CFG_LEN:    r_pat_len <= i_cfg_wdata[LEN_W-1:0];
                CFG_BASE:   r_base    <= i_cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp length: zero acts as one, oversize acts as the window depth
    always_comb begin
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_pat_len;
        end
    end

    assign w_sig = {r_pat_hi, r_pat_lo};

    // take a word whenever the output register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // shift only while still searching; clear on the region's last byte
    assign w_ctl.shift = w_accept && !r_done;
    assign w_ctl.clear = w_accept && s_axis_tlast;

    // window row: cell 0 takes the newest byte, each cell hands its byte on
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [LEN_W-1:0] w_idx;
        logic             w_used;

        // cell k lines up with signature byte n-1-k
        assign w_used = LEN_W'(k) < w_len;
        assign w_idx  = w_len - LEN_W'(1) - LEN_W'(k);

        if (k == 0) begin : g_head
            assign w_cell_in[k]  = s_axis_tdata[7:0];
            assign w_valid_in[k] = 1'b1;
        end else begin : g_link
            assign w_cell_in[k]  = w_cell_byte[k-1];
            assign w_valid_in[k] = w_cell_valid[k-1];
        end

        wbss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (w_cell_in[k]),
            .i_valid (w_valid_in[k]),
            .i_sig   (w_sig[8*w_idx[3:0] +: 8]),
            .i_wild  (r_wild[w_idx[3:0]]),
            .i_used  (w_used),
            .o_byte  (w_cell_byte[k]),
            .o_valid (w_cell_valid[k]),
            .o_ok    (w_cell_ok[k])
        );
    end

    // every used cell valid and agreeing means a full match
    assign w_match      = &w_cell_ok;
    assign w_emit       = w_accept && !r_done && (w_match || s_axis_tlast);
    assign w_match_addr = r_base + r_offset - ADDR_W'(w_len) + ADDR_W'(1);

    always_comb begin
        n_offset    = r_offset;
        n_done      = r_done;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_ctl.shift) begin
            n_offset = r_offset + ADDR_W'(1);
            if (w_match) begin
                n_done = 1'b1;
            end
        end
        if (w_ctl.clear) begin
            n_offset = '0;
            n_done   = 1'b0;
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_offset    <= n_offset;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result payload until the next emitted word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_found <= w_match;
            r_out_addr  <= w_match ? w_match_addr : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_found;

endmodule

// File: rtl/core/wbss_checker.sv
module wbss_checker
    import wbss_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [ADDR_W-1:0]      m_axis_tdata,
    input logic                   m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a not-found word always carries address zero
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero address");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    // a new not-found word follows only the last byte of a region
    a_nf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && !m_axis_tuser |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("not-found result without region end");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

endmodule

bind wildcard_byte_signature_scan wbss_checker u_wbss_checker (.*);
